/* rtl/line_rectangle_clipper_defines.svh */
// Assertion macros shared by the clipper RTL.
// Depends on nothing; define ASSERT_OFF to drop all checks.
`ifndef LINE_RECTANGLE_CLIPPER_DEFINES_SVH
`define LINE_RECTANGLE_CLIPPER_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition");
`else
`define ASSERT_RST(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

/* rtl/lrc_pkg.sv */
// Package for the line rectangle clipper: constants, outcode codes, states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lrc_pkg;
  localparam int unsigned CoordWidthDef   = 24;
  localparam int unsigned MaxClipStepsDef = 8;
  localparam int unsigned CoordMaxW       = 32;
  localparam int unsigned FifoDepth       = 2;
  localparam int unsigned CfgIdxW         = 2;

  typedef logic [3:0] outcode_t;

  localparam outcode_t CODE_TOP    = 4'h1;
  localparam outcode_t CODE_BOTTOM = 4'h2;
  localparam outcode_t CODE_RIGHT  = 4'h4;
  localparam outcode_t CODE_LEFT   = 4'h8;

  localparam logic [CfgIdxW-1:0] REG_X_MIN = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_X_MAX = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_Y_MIN = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_Y_MAX = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_MUL,
    ST_DIV,
    ST_UPD
  } back_state_e;

  function automatic outcode_t outcode(
    input logic signed [CoordMaxW-1:0] x,
    input logic signed [CoordMaxW-1:0] y,
    input logic signed [CoordMaxW-1:0] xmin,
    input logic signed [CoordMaxW-1:0] xmax,
    input logic signed [CoordMaxW-1:0] ymin,
    input logic signed [CoordMaxW-1:0] ymax
  );
    outcode_t c;
    c = '0;
    if (y > ymax) begin
      c = c | CODE_TOP;
    end else if (y < ymin) begin
      c = c | CODE_BOTTOM;
    end
    if (x > xmax) begin
      c = c | CODE_RIGHT;
    end else if (x < xmin) begin
      c = c | CODE_LEFT;
    end
    return c;
  endfunction
endpackage
`default_nettype wire

/* rtl/lrc_front.sv */
// Front end: accepts segments, computes both endpoint outcodes, pushes to queue.
// Depends on lrc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lrc_front #(
  parameter int unsigned COORD_WIDTH = lrc_pkg::CoordWidthDef,
  parameter int unsigned TDATA_W     = 96
) (
  input  wire logic                          s_tvalid_i,
  output logic                               s_tready_o,
  input  wire logic [TDATA_W-1:0]            s_tdata_i,
  input  wire logic signed [COORD_WIDTH-1:0] win_x_min_i,
  input  wire logic signed [COORD_WIDTH-1:0] win_x_max_i,
  input  wire logic signed [COORD_WIDTH-1:0] win_y_min_i,
  input  wire logic signed [COORD_WIDTH-1:0] win_y_max_i,
  input  wire logic                          q_full_i,
  output logic                               q_push_o,
  output logic [4*COORD_WIDTH+7:0]           q_data_o
);
  import lrc_pkg::*;
  localparam int unsigned W = COORD_WIDTH;

  logic signed [W-1:0] x0, y0, x1, y1;
  outcode_t            c0, c1;

  assign x0 = s_tdata_i[W-1:0];
  assign y0 = s_tdata_i[2*W-1:W];
  assign x1 = s_tdata_i[3*W-1:2*W];
  assign y1 = s_tdata_i[4*W-1:3*W];

  assign c0 = outcode(CoordMaxW'(x0), CoordMaxW'(y0), CoordMaxW'(win_x_min_i),
                      CoordMaxW'(win_x_max_i), CoordMaxW'(win_y_min_i),
                      CoordMaxW'(win_y_max_i));
  assign c1 = outcode(CoordMaxW'(x1), CoordMaxW'(y1), CoordMaxW'(win_x_min_i),
                      CoordMaxW'(win_x_max_i), CoordMaxW'(win_y_min_i),
                      CoordMaxW'(win_y_max_i));

  assign s_tready_o = !q_full_i;
  assign q_push_o   = s_tvalid_i && !q_full_i;
  assign q_data_o   = {c1, c0, y1, x1, y0, x0};
endmodule
`default_nettype wire

/* rtl/lrc_fifo.sv */
// Small register queue between front and back ends.
// Depends on lrc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "line_rectangle_clipper_defines.svh"
module lrc_fifo #(
  parameter int unsigned WIDTH = 104,
  parameter int unsigned DEPTH = lrc_pkg::FifoDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      rdata_o
);
  import lrc_pkg::*;
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    count_q, count_d;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  `ASSERT_RST(a_count_bound, clk_i, rst_ni, count_q <= CW'(DEPTH))
  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o)
  `ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && !valid_o)
endmodule
`default_nettype wire

/* rtl/lrc_back.sv */
// Back end: iterative clip engine (multiply, serial divide, edge update)
// and output register. Depends on lrc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "line_rectangle_clipper_defines.svh"
module lrc_back #(
  parameter int unsigned COORD_WIDTH    = lrc_pkg::CoordWidthDef,
  parameter int unsigned MAX_CLIP_STEPS = lrc_pkg::MaxClipStepsDef,
  parameter int unsigned TDATA_W        = 96
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_valid_i,
  input  wire logic [4*COORD_WIDTH+7:0]      q_data_i,
  output logic                               q_pop_o,
  input  wire logic signed [COORD_WIDTH-1:0] win_x_min_i,
  input  wire logic signed [COORD_WIDTH-1:0] win_x_max_i,
  input  wire logic signed [COORD_WIDTH-1:0] win_y_min_i,
  input  wire logic signed [COORD_WIDTH-1:0] win_y_max_i,
  output logic                               m_tvalid_o,
  input  wire logic                          m_tready_i,
  output logic [TDATA_W-1:0]                 m_tdata_o,
  output logic                               m_tuser_o
);
  import lrc_pkg::*;
  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned SW = $clog2(MAX_CLIP_STEPS + 1);
  localparam int unsigned NW = $clog2(2*W + 1);

  function automatic logic [W-1:0] mag_of(input logic signed [W:0] v);
    logic signed [W:0] a;
    a = v[W] ? -v : v;
    return a[W-1:0];
  endfunction

  back_state_e state_q, state_d;
  logic [SW-1:0] steps_q, steps_d;
  logic          out_valid_q, out_valid_d;
  logic          load_out, done_acc;

  logic signed [W-1:0] x0_q, y0_q, x1_q, y1_q;
  outcode_t            c0_q, c1_q;
  logic [W-1:0]        mag_d_q, mag_n_q, den_q, hi_q, lo_q, rem_q;
  logic                neg_q, move_x_q, sel0_q;
  logic signed [W-1:0] base_q, fixed_q;
  logic [NW-1:0]       cnt_q;
  logic                acc_q;
  logic signed [W-1:0] ox0_q, oy0_q, ox1_q, oy1_q;

  // clip step setup
  outcode_t            c_sel;
  logic signed [W:0]   dx, dy, num, d_sel, den_sel;
  logic signed [W-1:0] edge_val;
  logic                mv_x;

  always_comb begin
    c_sel    = (c0_q != '0) ? c0_q : c1_q;
    dx       = (W+1)'(x1_q) - (W+1)'(x0_q);
    dy       = (W+1)'(y1_q) - (W+1)'(y0_q);
    mv_x     = 1'b1;
    edge_val = win_y_max_i;
    priority if ((c_sel & CODE_TOP) != '0) begin
      edge_val = win_y_max_i;
    end else if ((c_sel & CODE_BOTTOM) != '0) begin
      edge_val = win_y_min_i;
    end else if ((c_sel & CODE_RIGHT) != '0) begin
      mv_x     = 1'b0;
      edge_val = win_x_max_i;
    end else begin
      mv_x     = 1'b0;
      edge_val = win_x_min_i;
    end
    num     = mv_x ? (W+1)'(edge_val) - (W+1)'(y0_q)
                   : (W+1)'(edge_val) - (W+1)'(x0_q);
    d_sel   = mv_x ? dx : dy;
    den_sel = mv_x ? dy : dx;
  end

  // restoring divide step over the full double-width product;
  // the quotient can exceed W bits on an inverted window, only its low bits count
  logic [W:0]   div_t, div_diff;
  logic         div_ge;
  assign div_t    = {rem_q, hi_q[W-1]};
  assign div_diff = div_t - {1'b0, den_q};
  assign div_ge   = (div_t >= {1'b0, den_q});

  // edge point update
  logic signed [W:0]   upd_sum;
  logic signed [W-1:0] new_c, new_x, new_y;
  outcode_t            new_code;
  always_comb begin
    upd_sum  = neg_q ? (W+1)'(base_q) - signed'({1'b0, lo_q})
                     : (W+1)'(base_q) + signed'({1'b0, lo_q});
    new_c    = upd_sum[W-1:0];
    new_x    = move_x_q ? new_c : fixed_q;
    new_y    = move_x_q ? fixed_q : new_c;
    new_code = outcode(CoordMaxW'(new_x), CoordMaxW'(new_y),
                       CoordMaxW'(win_x_min_i), CoordMaxW'(win_x_max_i),
                       CoordMaxW'(win_y_min_i), CoordMaxW'(win_y_max_i));
  end

  always_comb begin
    state_d     = state_q;
    steps_d     = steps_q;
    q_pop_o     = 1'b0;
    load_out    = 1'b0;
    done_acc    = ((c0_q | c1_q) == '0);
    out_valid_d = (out_valid_q && !m_tready_i);
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          steps_d = '0;
          state_d = ST_TEST;
        end
      end
      ST_TEST: begin
        if (done_acc || ((c0_q & c1_q) != '0) ||
            (steps_q >= SW'(MAX_CLIP_STEPS))) begin
          if (!out_valid_q || m_tready_i) begin
            load_out    = 1'b1;
            out_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == NW'(1)) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        steps_d = steps_q + 1'b1;
        state_d = ST_TEST;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      steps_q     <= steps_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      x0_q <= q_data_i[W-1:0];
      y0_q <= q_data_i[2*W-1:W];
      x1_q <= q_data_i[3*W-1:2*W];
      y1_q <= q_data_i[4*W-1:3*W];
      c0_q <= q_data_i[4*W+3:4*W];
      c1_q <= q_data_i[4*W+7:4*W+4];
    end
    if (state_q == ST_TEST) begin
      mag_d_q  <= mag_of(d_sel);
      mag_n_q  <= mag_of(num);
      den_q    <= mag_of(den_sel);
      neg_q    <= d_sel[W] ^ num[W] ^ den_sel[W];
      move_x_q <= mv_x;
      sel0_q   <= (c0_q != '0);
      base_q   <= mv_x ? x0_q : y0_q;
      fixed_q  <= edge_val;
    end
    if (state_q == ST_MUL) begin
      {hi_q, lo_q} <= (2*W)'(mag_d_q) * (2*W)'(mag_n_q);
      rem_q        <= '0;
      cnt_q        <= NW'(2*W);
    end
    if (state_q == ST_DIV) begin
      rem_q        <= div_ge ? div_diff[W-1:0] : div_t[W-1:0];
      {hi_q, lo_q} <= {hi_q[W-2:0], lo_q, div_ge};
      cnt_q        <= cnt_q - 1'b1;
    end
    if (state_q == ST_UPD) begin
      if (sel0_q) begin
        x0_q <= new_x;
        y0_q <= new_y;
        c0_q <= new_code;
      end else begin
        x1_q <= new_x;
        y1_q <= new_y;
        c1_q <= new_code;
      end
    end
    if (load_out) begin
      acc_q <= done_acc;
      ox0_q <= x0_q;
      oy0_q <= y0_q;
      ox1_q <= x1_q;
      oy1_q <= y1_q;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = acc_q;
  assign m_tdata_o  = TDATA_W'({oy1_q, ox1_q, oy0_q, ox0_q});

  `ASSERT_RST(a_steps_bound, clk_i, rst_ni, steps_q <= SW'(MAX_CLIP_STEPS))
  `ASSERT_RST(a_rem_below_den, clk_i, rst_ni, (state_q == ST_DIV) |-> (rem_q < den_q))
  `ASSERT_NEVER(a_den_nonzero, clk_i, rst_ni, (state_q == ST_DIV) && (den_q == '0))
endmodule
`default_nettype wire

/* rtl/line_rectangle_clipper.sv */
// Cohen-Sutherland line clipper against a window held in four registers.
// Slave stream in: segment endpoints. Master stream out: accept flag in
// tuser, clipped endpoints in tdata. Config channel writes the window edges.
// Register index 0..3: x_min, x_max, y_min, y_max (signed Q15.8).
// The front end computes outcodes and fills a two-word queue; the back end
// clips one segment at a time and keeps a registered output word, so a new
// segment is taken while a finished result waits for the receiver.
// Each clip step runs a test state, a single multiply state, the bit-serial
// divider (one quotient bit per cycle over the double-width product) and an
// edge update state. A segment takes k clip steps, 0 <= k <= MAX_CLIP_STEPS.
// When the receiver stalls, the back end finishes its segment, holds it until
// the output word frees up, and the queue then fills; s_axis_tready drops
// when it is full. Reset opens the window to the whole coordinate range and
// empties the queue and output. Config writes are always ready.
`timescale 1ns / 1ps
`default_nettype none
module line_rectangle_clipper #(
  parameter int unsigned COORD_WIDTH    = lrc_pkg::CoordWidthDef,
  parameter int unsigned MAX_CLIP_STEPS = lrc_pkg::MaxClipStepsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // start_x, start_y, end_x, end_y
  input  wire logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y
  output logic [((4*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // accepted
  output logic                              m_axis_tuser,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [lrc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [COORD_WIDTH-1:0]       cfg_data_i
);
  import lrc_pkg::*;
  localparam int unsigned W       = COORD_WIDTH;
  localparam int unsigned TDATA_W = ((4*COORD_WIDTH+7)/8)*8;
  localparam int unsigned QW      = 4*COORD_WIDTH+8;

  logic signed [W-1:0] x_min_q, x_max_q, y_min_q, y_max_q;
  logic                q_push, q_full, q_pop, q_valid;
  logic [QW-1:0]       q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q <= {1'b1, {(W-1){1'b0}}};
      x_max_q <= {1'b0, {(W-1){1'b1}}};
      y_min_q <= {1'b1, {(W-1){1'b0}}};
      y_max_q <= {1'b0, {(W-1){1'b1}}};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_X_MIN: x_min_q <= cfg_data_i;
        REG_X_MAX: x_max_q <= cfg_data_i;
        REG_Y_MIN: y_min_q <= cfg_data_i;
        REG_Y_MAX: y_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lrc_front #(.COORD_WIDTH(W), .TDATA_W(TDATA_W)) u_front (
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .win_x_min_i (x_min_q),
    .win_x_max_i (x_max_q),
    .win_y_min_i (y_min_q),
    .win_y_max_i (y_max_q),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  lrc_fifo #(.WIDTH(QW), .DEPTH(FifoDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  lrc_back #(
    .COORD_WIDTH(W), .MAX_CLIP_STEPS(MAX_CLIP_STEPS), .TDATA_W(TDATA_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .win_x_min_i (x_min_q),
    .win_x_max_i (x_max_q),
    .win_y_min_i (y_min_q),
    .win_y_max_i (y_max_q),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser)
  );
endmodule
`default_nettype wire

/* dv/line_rectangle_clipper_tb.sv */
// Self-checking testbench for line_rectangle_clipper: drives segments on the
// slave stream, predicts clipped segments, checks the master stream words.
// Depends on lrc_pkg and the line_rectangle_clipper RTL.
`timescale 1ns / 1ps
module line_rectangle_clipper_tb;
  import lrc_pkg::*;

  localparam int CW = 24;
  localparam int MAX_STEPS = 8;
  localparam longint CMIN = -(longint'(1) <<< (CW - 1));
  localparam longint CMAX = (longint'(1) <<< (CW - 1)) - 1;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic          accepted;
    logic [CW-1:0] sx;
    logic [CW-1:0] sy;
    logic [CW-1:0] ex;
    logic [CW-1:0] ey;
  } segment_t;

  class clip_scoreboard;
    longint   win_xmin, win_xmax, win_ymin, win_ymax;
    segment_t clipped_q[$];
    int       mismatches;

    function new();
      win_xmin = CMIN; win_xmax = CMAX; win_ymin = CMIN; win_ymax = CMAX;
      mismatches = 0;
    endfunction

    function void set_window(logic [CfgIdxW-1:0] idx, logic [CW-1:0] val);
      longint v;
      v = longint'(signed'(val));
      case (idx)
        REG_X_MIN: win_xmin = v;
        REG_X_MAX: win_xmax = v;
        REG_Y_MIN: win_ymin = v;
        REG_Y_MAX: win_ymax = v;
        default: ;
      endcase
    endfunction

    function outcode_t region(longint x, longint y);
      outcode_t c;
      c = '0;
      if (y > win_ymax) c |= CODE_TOP;
      else if (y < win_ymin) c |= CODE_BOTTOM;
      if (x > win_xmax) c |= CODE_RIGHT;
      else if (x < win_xmin) c |= CODE_LEFT;
      return c;
    endfunction

    function longint edge_point(longint p0, longint d, longint num, longint den);
      bit     neg;
      longint q;
      neg = ((d < 0) != (num < 0)) != (den < 0);
      if (den == 0) q = 0;
      else q = ((d < 0 ? -d : d) * (num < 0 ? -num : num)) / (den < 0 ? -den : den);
      return neg ? p0 - q : p0 + q;
    endfunction

    function void note_input(logic [95:0] word);
      longint   x0, y0, x1, y1, x, y;
      outcode_t c0, c1, c;
      int       steps;
      segment_t r;
      x0 = longint'(signed'(word[23:0]));
      y0 = longint'(signed'(word[47:24]));
      x1 = longint'(signed'(word[71:48]));
      y1 = longint'(signed'(word[95:72]));
      c0 = region(x0, y0);
      c1 = region(x1, y1);
      steps = 0;
      r.accepted = 1'b0;
      forever begin
        if ((c0 | c1) == '0) begin
          r.accepted = 1'b1;
          break;
        end
        if ((c0 & c1) != '0 || steps >= MAX_STEPS) break;
        c = (c0 != '0) ? c0 : c1;
        if (c & CODE_TOP) begin
          x = edge_point(x0, x1 - x0, win_ymax - y0, y1 - y0);
          y = win_ymax;
        end else if (c & CODE_BOTTOM) begin
          x = edge_point(x0, x1 - x0, win_ymin - y0, y1 - y0);
          y = win_ymin;
        end else if (c & CODE_RIGHT) begin
          x = win_xmax;
          y = edge_point(y0, y1 - y0, win_xmax - x0, x1 - x0);
        end else begin
          x = win_xmin;
          y = edge_point(y0, y1 - y0, win_xmin - x0, x1 - x0);
        end
        if (c0 != '0) begin
          x0 = x; y0 = y; c0 = region(x0, y0);
        end else begin
          x1 = x; y1 = y; c1 = region(x1, y1);
        end
        steps++;
      end
      r.sx = x0[CW-1:0]; r.sy = y0[CW-1:0];
      r.ex = x1[CW-1:0]; r.ey = y1[CW-1:0];
      clipped_q.push_back(r);
    endfunction

    function void check_result(logic acc, logic [95:0] word);
      segment_t got, exp_seg;
      got = {acc, word[23:0], word[47:24], word[71:48], word[95:72]};
      if (clipped_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
        return;
      end
      exp_seg = clipped_q.pop_front();
      if (got.accepted !== exp_seg.accepted || got.sx !== exp_seg.sx ||
          got.sy !== exp_seg.sy || got.ex !== exp_seg.ex || got.ey !== exp_seg.ey) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp acc=%0d %h %h %h %h, got acc=%0d %h %h %h %h",
                   exp_seg.accepted, exp_seg.sx, exp_seg.sy, exp_seg.ex, exp_seg.ey,
                   got.accepted, got.sx, got.sy, got.ex, got.ey);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [95:0]         s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [95:0]         m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CW-1:0]       cfg_data_i;

  clip_scoreboard sb;
  int  send_idle_pct, recv_stall_pct;
  bit  hold_off_req;
  int  hold_cnt;
  int  quiet_cycles;

  line_rectangle_clipper u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_req = 1'b0;
    hold_cnt = 0;
    quiet_cycles = 0;
    sb = new();
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: random stalls plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      m_axis_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_off_req) begin
      m_axis_tready <= 1'b0;
      hold_cnt <= 400;
      hold_off_req = 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("line_rectangle_clipper verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, longint val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[CW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_window(idx, val[CW-1:0]);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_window(longint xmin, longint xmax, longint ymin, longint ymax);
    write_reg(REG_X_MIN, xmin);
    write_reg(REG_X_MAX, xmax);
    write_reg(REG_Y_MIN, ymin);
    write_reg(REG_Y_MAX, ymax);
  endtask

  // segment word stays valid until the next call decides to idle or replace it
  task automatic send_segment(longint x0, longint y0, longint x1, longint y1);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {y1[CW-1:0], x1[CW-1:0], y0[CW-1:0], x0[CW-1:0]};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.clipped_q.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  function automatic longint near(longint lo, longint hi);
    longint a, b, span, v;
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    span = (b - a) / 2 + 64;
    v = a - span + longint'($urandom_range(32'(b - a + 2 * span)));
    if (v < CMIN) v = CMIN;
    if (v > CMAX) v = CMAX;
    return v;
  endfunction

  function automatic longint any_coord();
    return longint'(signed'(CW'($urandom)));
  endfunction

  longint wins[5][4] = '{
    '{CMIN, CMAX, CMIN, CMAX},
    '{-1000, 1000, -500, 800},
    '{CMIN, CMAX, -3, 3},
    '{2000, -2000, 1500, -1500},
    '{300, 300, -700, -700}
  };

  initial begin
    longint xmin, xmax, ymin, ymax;
    #1;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: default window first, then a small one
    send_segment(CMIN, CMIN, CMAX, CMAX);
    send_segment(CMAX, CMIN, CMIN, CMAX);
    drain();
    set_window(-1000, 1000, -500, 800);
    send_segment(0, 0, 100, -100);              // inside
    send_segment(-5000, 0, -2000, 300);         // both left: rejected
    send_segment(0, 0, 0, 5000);                // crosses top
    send_segment(0, 0, 0, -5000);               // crosses bottom
    send_segment(0, 0, 9000, 100);              // crosses right
    send_segment(0, 0, -9000, 100);             // crosses left
    send_segment(-3000, -2000, 3000, 2500);     // both outside, crossing
    send_segment(-3000, 700, -700, 3000);       // corner miss after clipping
    send_segment(CMIN, CMIN, CMAX, CMAX);
    send_segment(CMAX, CMAX, CMIN, CMIN);
    send_segment(CMIN, 0, CMAX, 0);
    send_segment(0, CMAX, 0, CMIN);
    send_segment(1000, 800, 1000, 800);         // point on corner
    send_segment(5000, 5000, 5000, 5000);       // point outside
    send_segment(-1000, -500, 1000, 800);       // exactly on the edges
    send_segment(CMAX, 1, CMIN, -1);
    drain();
    set_window(2000, -2000, 1500, -1500);       // inverted: step guard
    send_segment(-3000, -3000, 3000, 3000);
    send_segment(0, 0, 10, 10);
    drain();

    for (int p = 0; p < 8; p++) begin
      xmin = wins[p % 5][0]; xmax = wins[p % 5][1];
      ymin = wins[p % 5][2]; ymax = wins[p % 5][3];
      set_window(xmin, xmax, ymin, ymax);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      for (int i = 0; i < 88; i++) begin
        if (p == 4 && i == 10) hold_off_req = 1'b1;
        if ($urandom_range(99) < 65)
          send_segment(near(xmin, xmax), near(ymin, ymax), near(xmin, xmax), near(ymin, ymax));
        else
          send_segment(any_coord(), any_coord(), any_coord(), any_coord());
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.clipped_q.size() == 0) begin
      $display("line_rectangle_clipper verification clean");
    end else begin
      $display("line_rectangle_clipper verification failed");
    end
    $finish;
  end
endmodule
